### rtl/kipt_pkg.sv
package kipt_pkg;

    localparam int unsigned ENTRIES_DEF = 64;
    localparam int unsigned CMD_W = 2;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned ID_W = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned PROD_W = ID_W + 1 + TIME_W;

    localparam logic [ID_W-1:0] RATE_LIMIT_RST = 16'd40;
    localparam logic [ID_W-1:0] LOW_LIMIT_RST = 16'd20;

    typedef enum logic [CMD_W-1:0] {
        CMD_UPDATE = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_HIT      = 3'd3,
        ST_MISS     = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RATE_LIMIT = 1'd0,
        REG_LOW_LIMIT  = 1'd1
    } t_reg;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] tm;
        logic              low;
        logic              seq;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

### rtl/kipt_if.sv
interface kipt_req_if;
    import kipt_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   id_value;
    logic [TIME_W-1:0] meas_time;
    logic [TIME_W-1:0] now_time;
    modport source (output valid, cmd, addr, id_value, meas_time, now_time, input ready);
    modport sink (input valid, cmd, addr, id_value, meas_time, now_time, output ready);
endinterface

interface kipt_rsp_if;
    import kipt_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     found_id;
    logic                seq_flag;
    logic                low_id_flag;
    logic [TIME_W-1:0]   stored_time;
    modport source (output valid, status, found_id, seq_flag, low_id_flag, stored_time,
                    input ready);
    modport sink (input valid, status, found_id, seq_flag, low_id_flag, stored_time,
                  output ready);
endinterface

interface kipt_cfg_if;
    import kipt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/keyed_id_predictability_table.sv
// Channel   Dir  Handshake     Payload
// i_req     in   valid/ready   cmd, addr, id_value, meas_time, now_time
// o_rsp     out  valid/ready   status, found_id, seq_flag, low_id_flag, stored_time
// i_cfg     in   valid/ready   index, data (always ready)
//
// One request at a time; i_req.ready is high only while idle.
// Search reads one entry at a time through the single table RAM read port, S_READ then
// S_CMP per entry; a hit update adds S_MUL and S_JUDGE, an insert after a search S_TAIL and S_APPEND.
// Clear and unused commands go straight to the response state; the table needs no clearing pass.
// Reset (i_rst_n low, synchronous) empties the table and restores the limits.
// A stalled response holds in the output register until o_rsp.ready.
module keyed_id_predictability_table #(
    parameter int unsigned ENTRIES = kipt_pkg::ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kipt_req_if.sink    i_req,
    kipt_rsp_if.source  o_rsp,
    kipt_cfg_if.sink    i_cfg
);
    import kipt_pkg::*;

    localparam int unsigned IDX_W = $clog2(ENTRIES);
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_MUL,
        S_JUDGE,
        S_TAIL,
        S_APPEND,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_idx;
    t_cmd                r_cmd;
    logic [ADDR_W-1:0]   r_addr;
    logic [ID_W-1:0]     r_nid;
    logic [TIME_W-1:0]   r_mt;
    logic [TIME_W-1:0]   r_now;
    t_entry              r_ent;
    logic [PROD_W-1:0]   r_prod;
    logic [ID_W-1:0]     r_rate;
    logic [ID_W-1:0]     r_low;
    t_status             r_status;
    logic [ID_W-1:0]     r_found_id;
    logic                r_seq;
    logic                r_lowf;
    logic [TIME_W-1:0]   r_stime;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_entry              ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              rd_ent;
    logic                last_idx;
    logic [TIME_W-1:0]   age;
    logic [ID_W-1:0]     diff;
    logic                rate_ok;
    logic                both_low;
    logic [1:0]          n_flags;

    kipt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_ent   = t_entry'(ram_rdata);
    assign last_idx = (CNT_W'(r_idx) == r_count - CNT_W'(1));

    always_comb begin
        age = r_now - r_ent.tm;
        if (age == '0) begin
            age = TIME_W'(1);
        end
        diff = (r_nid > r_ent.id) ? r_nid - r_ent.id : r_ent.id - r_nid;
        rate_ok = (PROD_W'(diff) < r_prod);
        both_low = (r_nid <= r_low) && (r_ent.id <= r_low);
        n_flags = {r_ent.low, r_ent.seq};
        if (diff != '0 && rate_ok) begin
            n_flags = 2'b01;
        end
        n_flags[1] = both_low;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_ent;
        unique case (r_state)
            S_JUDGE: begin
                ram_we    = 1'b1;
                ram_wdata = '{addr: r_ent.addr, id: r_nid, tm: r_mt,
                              low: n_flags[1], seq: n_flags[0]};
            end
            S_TAIL: begin
                ram_we        = 1'b1;
                ram_wdata.low = r_ent.low | (r_ent.id <= r_low);
            end
            S_APPEND: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[IDX_W-1:0];
                ram_wdata = '{addr: r_addr, id: r_nid, tm: r_mt, low: 1'b0, seq: 1'b0};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_rate  <= RATE_LIMIT_RST;
            r_low   <= LOW_LIMIT_RST;
        end else begin
            if (i_cfg.valid) begin
                unique case (t_reg'(i_cfg.index))
                    REG_RATE_LIMIT: r_rate <= i_cfg.data;
                    REG_LOW_LIMIT:  r_low  <= i_cfg.data;
                    default:        r_rate <= r_rate;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_cmd      <= t_cmd'(i_req.cmd);
                        r_addr     <= i_req.addr;
                        r_nid      <= i_req.id_value;
                        r_mt       <= i_req.meas_time;
                        r_now      <= i_req.now_time;
                        r_idx      <= '0;
                        r_found_id <= '0;
                        r_seq      <= 1'b0;
                        r_lowf     <= 1'b0;
                        r_stime    <= '0;
                        unique case (t_cmd'(i_req.cmd))
                            CMD_CLEAR: begin
                                r_count  <= '0;
                                r_status <= ST_CLEARED;
                                r_state  <= S_OUT;
                            end
                            CMD_UPDATE: begin
                                if (r_count == '0) begin
                                    r_status <= ST_INSERTED;
                                    r_state  <= S_APPEND;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                            CMD_LOOKUP: begin
                                if (r_count == '0) begin
                                    r_status <= ST_MISS;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                                r_status <= ST_MISS;
                                r_state  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_ent <= rd_ent;
                    if (rd_ent.addr == r_addr) begin
                        if (r_cmd == CMD_LOOKUP) begin
                            r_status   <= ST_HIT;
                            r_found_id <= rd_ent.id;
                            r_seq      <= rd_ent.seq;
                            r_lowf     <= rd_ent.low;
                            r_stime    <= rd_ent.tm;
                            r_state    <= S_OUT;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end else if (last_idx) begin
                        if (r_cmd == CMD_LOOKUP) begin
                            r_status <= ST_MISS;
                            r_state  <= S_OUT;
                        end else if (r_count == CNT_W'(ENTRIES)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_OUT;
                        end else begin
                            r_status <= ST_INSERTED;
                            r_state  <= S_TAIL;
                        end
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_READ;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(({1'b0, r_rate} + 17'd1) * age);
                    r_state <= S_JUDGE;
                end
                S_JUDGE: begin
                    r_status <= ST_UPDATED;
                    r_state  <= S_OUT;
                end
                S_TAIL: begin
                    r_state <= S_APPEND;
                end
                S_APPEND: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_rsp.valid       = (r_state == S_OUT);
    assign o_rsp.status      = r_status;
    assign o_rsp.found_id    = r_found_id;
    assign o_rsp.seq_flag    = r_seq;
    assign o_rsp.low_id_flag = r_lowf;
    assign o_rsp.stored_time = r_stime;

endmodule

### rtl/kipt_ram.sv
module kipt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### tb/kipt_answer_check.sv
module kipt_answer_check (
    input  logic i_clk,
    input  logic i_rst_n,
    kipt_req_if  i_req,
    kipt_rsp_if  i_rsp,
    kipt_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import kipt_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   found_id;
        logic              seq_flag;
        logic              low_id_flag;
        logic [TIME_W-1:0] stored_time;
    } t_answer;

    t_answer           answers_due[$];
    t_entry            servers[ENTRIES_DEF];
    int unsigned       server_count;
    logic [ID_W-1:0]   rate_limit;
    logic [ID_W-1:0]   low_limit;
    int                mismatches = 0;

    function automatic int find_server(logic [ADDR_W-1:0] addr);
        int slot;
        slot = -1;
        for (int i = 0; i < server_count; i++) begin
            if (slot < 0 && servers[i].addr == addr) begin
                slot = i;
            end
        end
        return slot;
    endfunction

    function automatic t_answer predict_answer(t_cmd cmd, logic [ADDR_W-1:0] addr,
                                               logic [ID_W-1:0] nid, logic [TIME_W-1:0] mt,
                                               logic [TIME_W-1:0] now);
        t_answer           ans;
        int                slot;
        logic [ID_W-1:0]   oid;
        logic [ID_W-1:0]   diff;
        logic [TIME_W-1:0] age;
        ans = '0;
        ans.status = ST_MISS;
        case (cmd)
            CMD_UPDATE: begin
                slot = find_server(addr);
                if (slot >= 0) begin
                    oid = servers[slot].id;
                    diff = (nid > oid) ? nid - oid : oid - nid;
                    if (diff != 0) begin
                        age = now - servers[slot].tm;
                        if (age == 0) begin
                            age = 1;
                        end
                        if (32'(diff) / age <= 32'(rate_limit)) begin
                            servers[slot].seq = 1'b1;
                            servers[slot].low = 1'b0;
                        end
                    end
                    servers[slot].low = (nid <= low_limit) && (oid <= low_limit);
                    servers[slot].id = nid;
                    servers[slot].tm = mt;
                    ans.status = ST_UPDATED;
                end else if (server_count >= ENTRIES_DEF) begin
                    ans.status = ST_FULL;
                end else begin
                    if (server_count > 0 && servers[server_count-1].id <= low_limit) begin
                        servers[server_count-1].low = 1'b1;
                    end
                    servers[server_count] = '{addr: addr, id: nid, tm: mt, low: 1'b0, seq: 1'b0};
                    server_count++;
                    ans.status = ST_INSERTED;
                end
            end
            CMD_LOOKUP: begin
                slot = find_server(addr);
                if (slot >= 0) begin
                    ans.status = ST_HIT;
                    ans.found_id = servers[slot].id;
                    ans.seq_flag = servers[slot].seq;
                    ans.low_id_flag = servers[slot].low;
                    ans.stored_time = servers[slot].tm;
                end
            end
            CMD_CLEAR: begin
                server_count = 0;
                ans.status = ST_CLEARED;
            end
            default: begin
                ans.status = ST_MISS;
            end
        endcase
        return ans;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_answer();
        t_answer want;
        if (answers_due.size() == 0) begin
            $error("response with no request outstanding, status %0d", i_rsp.status);
            mismatches++;
        end else begin
            want = answers_due.pop_front();
            compare_field("status", 32'(want.status), 32'(i_rsp.status));
            compare_field("found_id", 32'(want.found_id), 32'(i_rsp.found_id));
            compare_field("seq_flag", 32'(want.seq_flag), 32'(i_rsp.seq_flag));
            compare_field("low_id_flag", 32'(want.low_id_flag), 32'(i_rsp.low_id_flag));
            compare_field("stored_time", want.stored_time, i_rsp.stored_time);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            answers_due.delete();
            server_count = 0;
            rate_limit = RATE_LIMIT_RST;
            low_limit = LOW_LIMIT_RST;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                check_answer();
            end
            if (i_req.valid && i_req.ready) begin
                answers_due.push_back(predict_answer(t_cmd'(i_req.cmd), i_req.addr,
                                                     i_req.id_value, i_req.meas_time,
                                                     i_req.now_time));
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg'(i_cfg.index))
                    REG_RATE_LIMIT: rate_limit = i_cfg.data;
                    REG_LOW_LIMIT:  low_limit = i_cfg.data;
                    default: ;
                endcase
            end
        end
        o_pending = answers_due.size();
        o_fail_count = mismatches;
    end

endmodule

### tb/keyed_id_predictability_table_tb.sv
module keyed_id_predictability_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kipt_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    bit   req_steady = 1'b0;
    bit   rsp_steady = 1'b0;
    bit   rsp_long_hold = 1'b0;
    bit   clears_ok = 1'b1;

    logic [ADDR_W-1:0] pool_addr[80];
    logic [ID_W-1:0]   pool_id[80];
    int unsigned       pool_n;
    logic [TIME_W-1:0] clock_s;

    kipt_req_if req_if();
    kipt_rsp_if rsp_if();
    kipt_cfg_if cfg_if();

    keyed_id_predictability_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    kipt_answer_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .i_cfg        (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    initial begin
        int unsigned stall;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rsp_long_hold) begin
                rsp_if.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                rsp_long_hold = 1'b0;
            end else begin
                stall = rsp_steady ? 0 : pick_gap();
                if (stall > 0) begin
                    rsp_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                rsp_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_request(t_cmd cmd, logic [ADDR_W-1:0] addr, logic [ID_W-1:0] id,
                                logic [TIME_W-1:0] mt, logic [TIME_W-1:0] now);
        int unsigned gap;
        gap = req_steady ? 0 : pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd <= cmd;
        req_if.addr <= addr;
        req_if.id_value <= id;
        req_if.meas_time <= mt;
        req_if.now_time <= now;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // hold off requests until every response is back
    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limits(logic [CFG_DATA_W-1:0] rate, logic [CFG_DATA_W-1:0] low);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_RATE_LIMIT;
        cfg_if.data <= rate;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.index <= REG_LOW_LIMIT;
        cfg_if.data <= low;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic new_pool(int unsigned n);
        pool_n = n;
        for (int i = 0; i < n; i++) begin
            pool_addr[i] = $urandom;
            pool_id[i] = ID_W'($urandom);
        end
        if (n > 2) begin
            pool_addr[0] = '0;
            pool_addr[1] = '1;
        end
    endtask

    task automatic send_update(int unsigned k);
        int unsigned       roll;
        logic [ID_W-1:0]   nid;
        logic [TIME_W-1:0] now;
        clock_s = clock_s + $urandom_range(0, 3);
        roll = $urandom_range(0, 9);
        if (roll < 6) begin
            nid = pool_id[k] + ID_W'($urandom_range(0, 120)) - ID_W'(60);
        end else if (roll < 8) begin
            nid = ID_W'($urandom_range(0, 40));
        end else if (roll == 8) begin
            nid = pool_id[k];
        end else begin
            nid = ID_W'($urandom);
        end
        roll = $urandom_range(0, 9);
        if (roll < 8) begin
            now = clock_s + $urandom_range(0, 4);
        end else if (roll == 8) begin
            now = clock_s + $urandom_range(0, 300);
        end else begin
            now = $urandom;
        end
        pool_id[k] = nid;
        send_request(CMD_UPDATE, pool_addr[k], nid, clock_s, now);
    endtask

    task automatic send_random_request();
        int unsigned roll;
        int unsigned k;
        roll = $urandom_range(0, 99);
        k = $urandom_range(0, pool_n - 1);
        if (roll < 3) begin
            send_request(t_cmd'($urandom_range(0, 3)), $urandom, ID_W'($urandom), $urandom,
                         $urandom);
        end else if (roll < 5 && clears_ok) begin
            send_request(CMD_CLEAR, $urandom, ID_W'($urandom), $urandom, $urandom);
        end else if (roll < 35) begin
            send_request(CMD_LOOKUP, pool_addr[k], ID_W'($urandom), $urandom, $urandom);
        end else begin
            send_update(k);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.cmd <= CMD_UPDATE;
        req_if.addr <= '0;
        req_if.id_value <= '0;
        req_if.meas_time <= '0;
        req_if.now_time <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= REG_RATE_LIMIT;
        cfg_if.data <= '0;
        clock_s = $urandom;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(CMD_LOOKUP, '0, '0, '0, '0);
        send_request(CMD_UPDATE, '0, '0, '0, '0);
        send_request(CMD_UPDATE, '1, '1, '1, '1);
        send_request(CMD_LOOKUP, '0, '1, '1, '1);
        send_request(CMD_UPDATE, '0, 16'd0, 32'd3, 32'd5);
        send_request(CMD_UPDATE, '0, 16'd30, 32'd10, 32'd10);
        send_request(CMD_UPDATE, '0, 16'd1000, 32'd11, 32'd10);
        send_request(CMD_UPDATE, '0, 16'd1100, 32'd12, 32'd5);
        send_request(CMD_UPDATE, '1, 16'd0, 32'd0, 32'd0);
        send_request(CMD_UPDATE, 32'h0A00_0001, 16'd20, 32'd100, 32'd100);
        send_request(CMD_UPDATE, 32'h0A00_0001, 16'd21, 32'd101, 32'd101);
        send_request(CMD_UPDATE, 32'h0A00_0001, 16'd20, 32'd102, 32'd102);
        send_request(CMD_UPDATE, 32'h0A00_0001, 16'd60, 32'd103, 32'd103);
        send_request(CMD_UPDATE, 32'h0A00_0001, 16'd101, 32'd104, 32'd104);
        send_request(CMD_LOOKUP, '0, '0, '0, '0);
        send_request(CMD_LOOKUP, '1, '0, '0, '0);
        send_request(CMD_LOOKUP, 32'h0A00_0001, '0, '0, '0);
        send_request(CMD_LOOKUP, 32'h0A00_0002, '0, '0, '0);
        send_request(CMD_NONE, '1, '1, '1, '1);
        send_request(CMD_CLEAR, '0, '0, '0, '0);
        send_request(CMD_LOOKUP, '0, '0, '0, '0);
        send_request(CMD_UPDATE, '0, 16'd7, 32'd9, 32'd9);
        send_request(CMD_LOOKUP, '0, '0, '0, '0);

        new_pool(6);
        repeat (100) send_random_request();
        drain();

        set_limits('0, '0);
        new_pool(12);
        req_steady = 1'b1;
        rsp_steady = 1'b1;
        repeat (80) send_random_request();
        req_steady = 1'b0;
        rsp_steady = 1'b0;
        drain();

        set_limits('1, '1);
        new_pool(20);
        rsp_long_hold = 1'b1;
        repeat (80) send_random_request();
        drain();

        // fill the table past its size, then keep working on it
        set_limits(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        send_request(CMD_CLEAR, '0, '0, '0, '0);
        new_pool(72);
        clears_ok = 1'b0;
        for (int i = 0; i < 72; i++) begin
            send_update(i);
        end
        repeat (60) send_random_request();
        clears_ok = 1'b1;
        drain();

        set_limits(RATE_LIMIT_RST, LOW_LIMIT_RST);
        new_pool(30);
        repeat (100) send_random_request();
        drain();

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/kipt_pkg.sv
rtl/kipt_if.sv
rtl/kipt_ram.sv
rtl/keyed_id_predictability_table.sv
tb/kipt_answer_check.sv
tb/keyed_id_predictability_table_tb.sv
